// ===== sv/pimw_pkg.sv =====
`default_nettype none
package pimw_pkg;
    localparam int COEF_W = 32;
    localparam int ORG_W  = 16;
    localparam int SIZE_W = 16;
    localparam int PX_W   = 17;
    localparam int PROD_W = COEF_W + PX_W;
    localparam int SUM_W  = PROD_W + 3;
    localparam int CFG_W  = 64;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_ROW0_AB  = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROW0C_1A = 3'd1;
    localparam logic [IDX_W-1:0] REG_ROW1_BC  = 3'd2;
    localparam logic [IDX_W-1:0] REG_ROW2_AB  = 3'd3;
    localparam logic [IDX_W-1:0] REG_ROW2_C   = 3'd4;
    localparam logic [IDX_W-1:0] REG_ORIGIN   = 3'd5;
    localparam logic [IDX_W-1:0] REG_SIZE     = 3'd6;

    typedef struct packed {
        logic signed [COEF_W-1:0] m00;
        logic signed [COEF_W-1:0] m01;
        logic signed [COEF_W-1:0] m02;
        logic signed [COEF_W-1:0] m10;
        logic signed [COEF_W-1:0] m11;
        logic signed [COEF_W-1:0] m12;
        logic signed [COEF_W-1:0] m20;
        logic signed [COEF_W-1:0] m21;
        logic signed [COEF_W-1:0] m22;
        logic signed [ORG_W-1:0]  ox;
        logic signed [ORG_W-1:0]  oy;
    } coef_t;

    typedef struct packed {
        logic [SUM_W-1:0] ax;
        logic [SUM_W-1:0] ay;
        logic [SUM_W-1:0] ad;
        logic             bad;
    } quot_in_t;
endpackage
`default_nettype wire

// ===== sv/pimw_front.sv =====
`default_nettype none
module pimw_front #(
    parameter int COORD_BITS = 12
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  pimw_pkg::coef_t             coef,
    input  wire                         in_valid,
    output logic                        in_ready,
    input  wire [COORD_BITS-1:0]        out_x,
    input  wire [COORD_BITS-1:0]        out_y,
    output logic                        q_valid,
    input  wire                         q_ready,
    output pimw_pkg::quot_in_t          q_data
);
    import pimw_pkg::*;

    localparam int NST = 4;

    logic [NST-1:0] v_reg, v_next, rdy;

    logic signed [PX_W-1:0]   px_reg, py_reg, px_next, py_next;
    logic signed [PROD_W-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [PROD_W-1:0] p0_next, p1_next, p2_next, p3_next, p4_next, p5_next;
    logic signed [SUM_W-1:0]  nx_reg, ny_reg, nz_reg, nx_next, ny_next, nz_next;
    quot_in_t                 q_reg, q_next;

    always_comb
    begin
        rdy[NST-1] = !v_reg[NST-1] || q_ready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
        v_next[0] = rdy[0] ? in_valid : v_reg[0];
        for (int k = 1; k < NST; k++)
        begin
            v_next[k] = rdy[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_comb
    begin
        px_next = $signed({{(PX_W-COORD_BITS){1'b0}}, out_x}) + PX_W'(coef.ox);
        py_next = $signed({{(PX_W-COORD_BITS){1'b0}}, out_y}) + PX_W'(coef.oy);
        p0_next = coef.m00 * px_reg;
        p1_next = coef.m01 * py_reg;
        p2_next = coef.m10 * px_reg;
        p3_next = coef.m11 * py_reg;
        p4_next = coef.m20 * px_reg;
        p5_next = coef.m21 * py_reg;
        nx_next = SUM_W'(p0_reg) + SUM_W'(p1_reg) + SUM_W'(coef.m02);
        ny_next = SUM_W'(p2_reg) + SUM_W'(p3_reg) + SUM_W'(coef.m12);
        nz_next = SUM_W'(p4_reg) + SUM_W'(p5_reg) + SUM_W'(coef.m22);
        q_next.ax  = nx_reg[SUM_W-1] ? SUM_W'(-nx_reg) : nx_reg;
        q_next.ay  = ny_reg[SUM_W-1] ? SUM_W'(-ny_reg) : ny_reg;
        q_next.ad  = nz_reg[SUM_W-1] ? SUM_W'(-nz_reg) : nz_reg;
        q_next.bad = (nz_reg == '0)
            || ((nx_reg != '0) && (nx_reg[SUM_W-1] != nz_reg[SUM_W-1]))
            || ((ny_reg != '0) && (ny_reg[SUM_W-1] != nz_reg[SUM_W-1]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            px_reg <= px_next;
            py_reg <= py_next;
        end
        if (rdy[1])
        begin
            p0_reg <= p0_next;
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            p3_reg <= p3_next;
            p4_reg <= p4_next;
            p5_reg <= p5_next;
        end
        if (rdy[2])
        begin
            nx_reg <= nx_next;
            ny_reg <= ny_next;
            nz_reg <= nz_next;
        end
        if (rdy[3])
        begin
            q_reg <= q_next;
        end
    end

    assign in_ready = rdy[0];
    assign q_valid  = v_reg[NST-1];
    assign q_data   = q_reg;
endmodule
`default_nettype wire

// ===== sv/pimw_div.sv =====
`default_nettype none
module pimw_div #(
    parameter int COORD_BITS = 12
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire [pimw_pkg::SIZE_W-1:0]         src_w,
    input  wire [pimw_pkg::SIZE_W-1:0]         src_h,
    input  wire                                q_valid,
    output logic                               q_ready,
    input  pimw_pkg::quot_in_t                 q_data,
    output logic                               out_valid,
    input  wire                                out_ready,
    output logic [COORD_BITS-1:0]              src_x,
    output logic [COORD_BITS-1:0]              src_y,
    output logic                               inside_res
);
    import pimw_pkg::*;

    localparam int NST = COORD_BITS + 2;
    localparam int WW  = SUM_W + COORD_BITS;

    typedef struct packed {
        logic [SUM_W-1:0]      rx;
        logic [SUM_W-1:0]      ry;
        logic [SUM_W-1:0]      ad;
        logic [COORD_BITS-1:0] qx;
        logic [COORD_BITS-1:0] qy;
        logic                  bad;
    } dstage_t;

    logic [NST-1:0] v_reg, v_next, rdy;
    dstage_t        st_reg  [0:COORD_BITS];
    dstage_t        st_next [0:COORD_BITS];
    logic [COORD_BITS-1:0] sx_reg, sy_reg, sx_next, sy_next;
    logic                  in_reg, in_next;
    logic [WW-1:0]         lim;

    always_comb
    begin
        rdy[NST-1] = !v_reg[NST-1] || out_ready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
        v_next[0] = rdy[0] ? q_valid : v_reg[0];
        for (int k = 1; k < NST; k++)
        begin
            v_next[k] = rdy[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_comb
    begin
        lim = {q_data.ad, {COORD_BITS{1'b0}}};
        st_next[0].rx  = q_data.ax;
        st_next[0].ry  = q_data.ay;
        st_next[0].ad  = q_data.ad;
        st_next[0].qx  = '0;
        st_next[0].qy  = '0;
        st_next[0].bad = q_data.bad
            || ({{COORD_BITS{1'b0}}, q_data.ax} >= lim)
            || ({{COORD_BITS{1'b0}}, q_data.ay} >= lim);
    end

    for (genvar k = 1; k <= COORD_BITS; k++)
    begin : g_step
        localparam int SH = COORD_BITS - k;
        logic [WW-1:0] dsh, wx, wy;
        always_comb
        begin
            dsh = WW'(st_reg[k-1].ad) << SH;
            wx  = {{COORD_BITS{1'b0}}, st_reg[k-1].rx};
            wy  = {{COORD_BITS{1'b0}}, st_reg[k-1].ry};
            st_next[k] = st_reg[k-1];
            if (wx >= dsh)
            begin
                st_next[k].rx     = SUM_W'(wx - dsh);
                st_next[k].qx[SH] = 1'b1;
            end
            if (wy >= dsh)
            begin
                st_next[k].ry     = SUM_W'(wy - dsh);
                st_next[k].qy[SH] = 1'b1;
            end
        end
    end

    always_comb
    begin
        in_next = !st_reg[COORD_BITS].bad
            && (SIZE_W'(st_reg[COORD_BITS].qx) < src_w)
            && (SIZE_W'(st_reg[COORD_BITS].qy) < src_h);
        sx_next = in_next ? st_reg[COORD_BITS].qx : '0;
        sy_next = in_next ? st_reg[COORD_BITS].qy : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= COORD_BITS; k++)
        begin
            if (rdy[k])
            begin
                st_reg[k] <= st_next[k];
            end
        end
        if (rdy[NST-1])
        begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
            in_reg <= in_next;
        end
    end

    assign q_ready    = rdy[0];
    assign out_valid  = v_reg[NST-1];
    assign src_x      = sx_reg;
    assign src_y      = sy_reg;
    assign inside_res = in_reg;

    a_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !inside_res) |-> (src_x == '0 && src_y == '0))
        else $error("outside point with nonzero coordinates");
    a_in_width: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && inside_res) |-> (SIZE_W'(src_x) < src_w && SIZE_W'(src_y) < src_h))
        else $error("inside point beyond source size");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("stalled result dropped");
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[0] |-> q_ready)
        else $error("empty entry stage refused a transfer");
endmodule
`default_nettype wire

// ===== sv/projective_inverse_map_warp_top.sv =====
// Projective inverse-mapping coordinate generator.
// Input channel: in_valid/in_ready with out_x, out_y (output pixel).
// Output channel: out_valid/out_ready with src_x, src_y and inside_res.
// Each output pixel is mapped through the inverse 3x3 matrix, divided by
// the homogeneous term and truncated; inside_res is set when the source
// point lies within source_size, otherwise src_x and src_y read zero.
// Configuration: cfg_we, cfg_index, cfg_data; write only while idle.
// Stages from input transfer to result valid: four multiply/sum stages,
// one range stage, one restoring quotient stage per coordinate bit and
// one output stage.
// Throughput: one pixel per cycle while the receiver holds out_ready.
// Reset loads the identity matrix, zero origin and zero size, and
// empties the pipeline.
// A receiver stall holds the result; bubbles ahead of it still fill, so
// the input keeps taking transfers until every stage is occupied.
`default_nettype none
module projective_inverse_map_warp_top #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            cfg_we,
    input  wire [pimw_pkg::IDX_W-1:0]      cfg_index,
    input  wire [pimw_pkg::CFG_W-1:0]      cfg_data,
    input  wire                            in_valid,
    output logic                           in_ready,
    input  wire [COORD_BITS-1:0]           out_x,
    input  wire [COORD_BITS-1:0]           out_y,
    output logic                           out_valid,
    input  wire                            out_ready,
    output logic [COORD_BITS-1:0]          src_x,
    output logic [COORD_BITS-1:0]          src_y,
    output logic                           inside_res
);
    import pimw_pkg::*;

    localparam logic [COEF_W-1:0] ONE = COEF_W'(1) << FRAC_BITS;

    logic [CFG_W-1:0] r0_reg, r1_reg, r2_reg, r3_reg;
    logic [31:0]      r4_reg, r5_reg, r6_reg;
    coef_t            coef;
    logic             q_valid, q_ready;
    quot_in_t         q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r0_reg <= {ONE, {COEF_W{1'b0}}};
            r1_reg <= '0;
            r2_reg <= {ONE, {COEF_W{1'b0}}};
            r3_reg <= '0;
            r4_reg <= ONE;
            r5_reg <= '0;
            r6_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROW0_AB:  r0_reg <= cfg_data;
                REG_ROW0C_1A: r1_reg <= cfg_data;
                REG_ROW1_BC:  r2_reg <= cfg_data;
                REG_ROW2_AB:  r3_reg <= cfg_data;
                REG_ROW2_C:   r4_reg <= cfg_data[31:0];
                REG_ORIGIN:   r5_reg <= cfg_data[31:0];
                REG_SIZE:     r6_reg <= cfg_data[31:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        coef.m00 = r0_reg[63:32];
        coef.m01 = r0_reg[31:0];
        coef.m02 = r1_reg[63:32];
        coef.m10 = r1_reg[31:0];
        coef.m11 = r2_reg[63:32];
        coef.m12 = r2_reg[31:0];
        coef.m20 = r3_reg[63:32];
        coef.m21 = r3_reg[31:0];
        coef.m22 = r4_reg;
        coef.ox  = r5_reg[31:16];
        coef.oy  = r5_reg[15:0];
    end

    pimw_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .coef     (coef),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_x    (out_x),
        .out_y    (out_y),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data)
    );

    pimw_div #(.COORD_BITS(COORD_BITS)) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_w      (r6_reg[31:16]),
        .src_h      (r6_reg[15:0]),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_data     (q_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .src_x      (src_x),
        .src_y      (src_y),
        .inside_res (inside_res)
    );
endmodule
`default_nettype wire

// ===== tb/projective_inverse_map_warp_top_tb.sv =====
`default_nettype none
module projective_inverse_map_warp_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pimw_pkg::*;

    localparam int CB = 12;
    localparam int LAT = CB + 6;

    typedef struct packed {
        logic [CB-1:0] sx;
        logic [CB-1:0] sy;
        logic          ins;
    } src_pt_t;

    typedef struct packed {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
    } pix_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [CB-1:0] out_x = '0;
    logic [CB-1:0] out_y = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [CB-1:0] src_x;
    logic [CB-1:0] src_y;
    logic inside_res;

    logic [63:0] regs [0:6];
    pix_t pix_q [$];
    src_pt_t exp_q [$];
    int errors = 0;
    int stall_hold = 0;
    bit drain_hold = 1'b0;
    bit mon_run = 1'b0;

    projective_inverse_map_warp_top #(.COORD_BITS(CB), .FRAC_BITS(16)) dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .out_x(out_x), .out_y(out_y), .out_valid(out_valid),
        .out_ready(out_ready), .src_x(src_x), .src_y(src_y),
        .inside_res(inside_res)
    );

    always #10 clk = ~clk;

    function automatic src_pt_t map_pixel(pix_t p);
        longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
        longint px, py, nx, ny, nz, w, h, ax, ay, az, qx, qy;
        bit okx, oky;
        src_pt_t r;
        m00 = longint'($signed(regs[0][63:32]));
        m01 = longint'($signed(regs[0][31:0]));
        m02 = longint'($signed(regs[1][63:32]));
        m10 = longint'($signed(regs[1][31:0]));
        m11 = longint'($signed(regs[2][63:32]));
        m12 = longint'($signed(regs[2][31:0]));
        m20 = longint'($signed(regs[3][63:32]));
        m21 = longint'($signed(regs[3][31:0]));
        m22 = longint'($signed(regs[4][31:0]));
        px = longint'(p.x) + longint'($signed(regs[5][31:16]));
        py = longint'(p.y) + longint'($signed(regs[5][15:0]));
        w = longint'(regs[6][31:16]);
        h = longint'(regs[6][15:0]);
        if (w > (1 << CB)) w = 1 << CB;
        if (h > (1 << CB)) h = 1 << CB;
        nx = m00 * px + m01 * py + m02;
        ny = m10 * px + m11 * py + m12;
        nz = m20 * px + m21 * py + m22;
        r = '0;
        if (nz != 0) begin
            ax = nx < 0 ? -nx : nx;
            ay = ny < 0 ? -ny : ny;
            az = nz < 0 ? -nz : nz;
            qx = ax / az;
            qy = ay / az;
            okx = (nx == 0) || ((nx > 0) == (nz > 0));
            oky = (ny == 0) || ((ny > 0) == (nz > 0));
            if (okx && oky && qx < w && qy < h) begin
                r.sx = qx[CB-1:0];
                r.sy = qy[CB-1:0];
                r.ins = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    int in_gap = 0;
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            exp_q.push_back(map_pixel({out_x, out_y}));
        end
        if (!in_valid || in_ready)
        begin
            if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pix_q.size() > 0 && !drain_hold)
            begin
                out_x <= pix_q[0].x;
                out_y <= pix_q[0].y;
                void'(pix_q.pop_front());
                in_valid <= 1'b1;
                in_gap <= gap_len();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    int out_gap = 0;
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (exp_q.size() == 0)
            begin
                $error("unexpected result transfer");
                errors++;
            end
            else
            begin
                if (src_x !== exp_q[0].sx)
                begin
                    $error("src_x exp %0d got %0d", exp_q[0].sx, src_x);
                    errors++;
                end
                if (src_y !== exp_q[0].sy)
                begin
                    $error("src_y exp %0d got %0d", exp_q[0].sy, src_y);
                    errors++;
                end
                if (inside_res !== exp_q[0].ins)
                begin
                    $error("inside_res exp %0d got %0d", exp_q[0].ins, inside_res);
                    errors++;
                end
                void'(exp_q.pop_front());
            end
        end
        if (stall_hold > 0)
        begin
            stall_hold <= stall_hold - 1;
            out_ready <= 1'b0;
        end
        else if (!mon_run)
        begin
            out_ready <= 1'b0;
        end
        else if (out_gap > 0)
        begin
            out_gap <= out_gap - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            out_gap <= gap_len();
        end
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx <= REG_SIZE)
            regs[idx] = idx >= REG_ROW2_C ? {32'h0, val[31:0]} : val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pix_q.size() > 0 || in_valid || exp_q.size() > 0)
            @(negedge clk);
        repeat (LAT + 4) @(posedge clk);
    endtask

    function automatic logic [63:0] rnd_pair(int mode);
        logic [31:0] a, b;
        a = $urandom();
        b = $urandom();
        if (mode == 1)
        begin
            a = $signed(a) >>> $urandom_range(8, 20);
            b = $signed(b) >>> $urandom_range(8, 20);
        end
        return {a, b};
    endfunction

    task automatic run_phase(int n, bit full);
        pix_t p;
        for (int i = 0; i < n; i++)
        begin
            if (full)
            begin
                p.x = CB'($urandom());
                p.y = CB'($urandom());
            end
            else
            begin
                p.x = CB'($urandom_range(0, 255));
                p.y = CB'($urandom_range(0, 255));
            end
            pix_q.push_back(p);
        end
    endtask

    initial
    begin
        regs[0] = 64'h0001_0000_0000_0000;
        regs[1] = 64'h0;
        regs[2] = 64'h0001_0000_0000_0000;
        regs[3] = 64'h0;
        regs[4] = 64'h0001_0000;
        regs[5] = 64'h0;
        regs[6] = 64'h0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        mon_run = 1'b1;
        repeat (2) @(posedge clk);

        pix_q.push_back('{12'h000, 12'h000});
        pix_q.push_back('{12'hfff, 12'hfff});
        wait_idle();

        write_reg(REG_SIZE, 64'h0000_0000_ffff_ffff);
        pix_q.push_back('{12'h000, 12'h000});
        pix_q.push_back('{12'hfff, 12'hfff});
        pix_q.push_back('{12'hfff, 12'h000});
        pix_q.push_back('{12'h123, 12'h456});
        wait_idle();

        write_reg(REG_ORIGIN, 64'h0000_0000_8000_7fff);
        pix_q.push_back('{12'h000, 12'h000});
        pix_q.push_back('{12'hfff, 12'hfff});
        wait_idle();

        write_reg(REG_ORIGIN, 64'h0);
        write_reg(REG_SIZE, 64'h0000_0000_0100_0080);
        write_reg(REG_ROW0_AB, 64'hffff_8000_0000_0000);
        write_reg(REG_ROW0C_1A, 64'h0000_8000_0000_0000);
        pix_q.push_back('{12'h000, 12'h000});
        pix_q.push_back('{12'h001, 12'h000});
        pix_q.push_back('{12'h002, 12'h005});
        wait_idle();

        write_reg(REG_ROW0_AB, 64'h0001_0000_0000_0000);
        write_reg(REG_ROW0C_1A, 64'h0);
        write_reg(REG_ROW2_C, 64'h0);
        pix_q.push_back('{12'h000, 12'h000});
        pix_q.push_back('{12'h010, 12'h010});
        wait_idle();
        write_reg(REG_ROW2_AB, 64'h0);
        write_reg(REG_ROW2_AB, 64'h0000_0100_0000_0200);
        write_reg(REG_ROW2_C, 64'h8000_0000);
        pix_q.push_back('{12'h000, 12'h000});
        pix_q.push_back('{12'hfff, 12'hfff});
        wait_idle();
        write_reg(REG_ROW2_C, 64'h7fff_ffff);
        write_reg(REG_ROW1_BC, 64'h7fff_ffff_8000_0000);
        write_reg(IDX_W'(REG_SIZE + 1), 64'hffff_ffff_ffff_ffff);
        pix_q.push_back('{12'hfff, 12'h000});
        pix_q.push_back('{12'h000, 12'hfff});
        wait_idle();

        for (int ph = 0; ph < 12; ph++)
        begin
            int md;
            md = ph % 3;
            if (md == 0)
            begin
                write_reg(REG_ROW0_AB, 64'h0001_0000_0000_0000 ^ ($urandom_range(0, 3) << 40));
                write_reg(REG_ROW0C_1A, {$urandom_range(0, 32'h0200_0000), 32'h0});
                write_reg(REG_ROW1_BC, {32'h0001_0000, 32'($urandom())});
                write_reg(REG_ROW2_AB, 64'h0);
                write_reg(REG_ROW2_C, 64'h0001_0000);
            end
            else
            begin
                write_reg(REG_ROW0_AB, rnd_pair(md));
                write_reg(REG_ROW0C_1A, rnd_pair(md));
                write_reg(REG_ROW1_BC, rnd_pair(md));
                write_reg(REG_ROW2_AB, rnd_pair(1));
                write_reg(REG_ROW2_C, {32'h0, 32'($urandom())});
            end
            write_reg(REG_ORIGIN, {32'h0, 32'($urandom())} & 64'h0000_0000_83ff_83ff);
            write_reg(REG_SIZE, ph == 11 ? 64'h0000_0000_ffff_ffff
                                         : {32'h0, 32'($urandom())} & 64'h0000_0000_1fff_1fff);
            run_phase(75, ph % 2 == 0);
            if (ph == 3)
            begin
                stall_hold = 300;
            end
            if (ph == 6)
            begin
                while (pix_q.size() > 40) @(negedge clk);
                drain_hold = 1'b1;
                @(negedge clk);
                while (in_valid || exp_q.size() > 0) @(negedge clk);
                drain_hold = 1'b0;
            end
            wait_idle();
        end

        if (errors == 0)
            $display("projective_inverse_map_warp_top_tb: done, clean");
        else
            $display("projective_inverse_map_warp_top_tb: done, errors");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("projective_inverse_map_warp_top_tb: done, errors");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
sv/pimw_pkg.sv
sv/pimw_front.sv
sv/pimw_div.sv
sv/projective_inverse_map_warp_top.sv
tb/projective_inverse_map_warp_top_tb.sv
